// ===== sv/fdep_pkg.sv =====
`default_nettype none
package fdep_pkg;

   localparam int NAME_LEN  = 64;
   localparam int IDX_W     = $clog2(NAME_LEN);
   localparam int MAX_CHARS = (NAME_LEN - 1 < 63) ? NAME_LEN - 1 : 63;
   localparam int CIDX_W    = 9;
   localparam int LFN_CHARS = 13;
   localparam int SN_LEN    = 11;

   localparam logic [7:0]  DELETED_MARK = 8'hE5;
   localparam logic [7:0]  LAST_LFN_BIT = 8'h40;
   localparam logic [4:0]  ORDER_MASK   = 5'h1F;
   localparam logic [3:0]  LFN_ATTR     = 4'hF;
   localparam int          ATTR_LABEL   = 3;
   localparam int          ATTR_DIR     = 4;
   localparam logic [15:0] PAD_CODE     = 16'hFFFF;
   localparam logic [7:0]  SPACE_CHAR   = 8'h20;
   localparam logic [6:0]  QMARK_CHAR   = 7'h3F;
   localparam logic [6:0]  DOT_CHAR     = 7'h2E;

   localparam logic [4:0] LFN_OFS [LFN_CHARS] = '{
      5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24, 5'd28, 5'd30
   };

   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_INFO = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   localparam logic [2:0] EM_NONE  = 3'd0;
   localparam logic [2:0] EM_END   = 3'd1;
   localparam logic [2:0] EM_INFO  = 3'd2;
   localparam logic [2:0] EM_LONG  = 3'd3;
   localparam logic [2:0] EM_SHORT = 3'd4;
   localparam logic [2:0] EM_DOT   = 3'd5;

   typedef struct packed {
      logic       take;
      logic       fin;
      logic       chunk_step;
      logic       ln_read;
      logic       ctr_clr;
      logic       ctr_inc;
      logic       ctr_set8;
      logic [2:0] emit;
   } fdep_cmd_type;

   typedef struct packed {
      logic drop;
      logic end_byte;
      logic last_byte;
      logic skip_entry;
      logic is_lfn;
      logic lfn_go;
      logic have_long;
      logic chunk_done;
      logic ln_more;
      logic name_sp;
      logic ctr_is8;
      logic ctr_is11;
      logic ext_blank;
      logic out_free;
   } fdep_sts_type;

   function automatic logic [6:0] lower_char(input logic [7:0] c);
      logic [6:0] r;
      if (c[7]) begin
         r = QMARK_CHAR;
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         r = c[6:0] + 7'h20;
      end else begin
         r = c[6:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== sv/fdep_if.sv =====
`default_nettype none
interface fdep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_directory;
   modport source (output valid, data_byte, start_directory, input ready);
   modport sink (input valid, data_byte, start_directory, output ready);
endinterface

interface fdep_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [6:0]  name_char;
   logic        is_directory;
   logic [31:0] file_size;
   logic [31:0] start_cluster;
   logic        last;
   modport source (output valid, kind, name_char, is_directory, file_size, start_cluster,
                    last, input ready);
   modport sink (input valid, kind, name_char, is_directory, file_size, start_cluster,
                 last, output ready);
endinterface
`default_nettype wire

// ===== sv/fdep_ram.sv =====
`default_nettype none
module fdep_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule
`default_nettype wire

// ===== sv/fdep_ctrl.sv =====
`default_nettype none
module fdep_ctrl import fdep_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire fdep_sts_type sts,
   output fdep_cmd_type      cmd
);
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_END     = 4'd1;
   localparam logic [3:0] S_FIN     = 4'd2;
   localparam logic [3:0] S_LFN     = 4'd3;
   localparam logic [3:0] S_LN_RD   = 4'd4;
   localparam logic [3:0] S_LN_EM   = 4'd5;
   localparam logic [3:0] S_SN_BASE = 4'd6;
   localparam logic [3:0] S_SN_DOT  = 4'd7;
   localparam logic [3:0] S_SN_EXT  = 4'd8;
   localparam logic [3:0] S_INFO    = 4'd9;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (sts.drop) begin
                  state_in = S_IDLE;
               end else if (sts.end_byte) begin
                  state_in = S_END;
               end else if (sts.last_byte) begin
                  state_in = S_FIN;
               end
            end
         end
         S_END: begin
            if (sts.out_free) begin
               cmd.emit = EM_END;
               state_in = S_IDLE;
            end
         end
         S_FIN: begin
            cmd.fin     = 1'b1;
            cmd.ctr_clr = 1'b1;
            if (sts.skip_entry) begin
               state_in = S_IDLE;
            end else if (sts.is_lfn) begin
               state_in = sts.lfn_go ? S_LFN : S_IDLE;
            end else begin
               state_in = sts.have_long ? S_LN_RD : S_SN_BASE;
            end
         end
         S_LFN: begin
            cmd.chunk_step = 1'b1;
            cmd.ctr_inc    = 1'b1;
            if (sts.chunk_done) begin
               state_in = S_IDLE;
            end
         end
         S_LN_RD: begin
            if (sts.ln_more) begin
               cmd.ln_read = 1'b1;
               state_in    = S_LN_EM;
            end else begin
               state_in = S_INFO;
            end
         end
         S_LN_EM: begin
            if (sts.out_free) begin
               cmd.emit    = EM_LONG;
               cmd.ctr_inc = 1'b1;
               state_in    = S_LN_RD;
            end
         end
         S_SN_BASE: begin
            if (sts.ctr_is8 || sts.name_sp) begin
               state_in = S_SN_DOT;
            end else if (sts.out_free) begin
               cmd.emit    = EM_SHORT;
               cmd.ctr_inc = 1'b1;
            end
         end
         S_SN_DOT: begin
            if (sts.ext_blank) begin
               state_in = S_INFO;
            end else if (sts.out_free) begin
               cmd.emit     = EM_DOT;
               cmd.ctr_set8 = 1'b1;
               state_in     = S_SN_EXT;
            end
         end
         S_SN_EXT: begin
            if (sts.ctr_is11 || sts.name_sp) begin
               state_in = S_INFO;
            end else if (sts.out_free) begin
               cmd.emit    = EM_SHORT;
               cmd.ctr_inc = 1'b1;
            end
         end
         S_INFO: begin
            if (sts.out_free) begin
               cmd.emit = EM_INFO;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ===== sv/fdep_dp.sv =====
`default_nettype none
module fdep_dp import fdep_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [7:0]   data_byte,
   input  wire logic         start_directory,
   input  wire fdep_cmd_type cmd,
   output fdep_sts_type      sts,
   input  wire logic         rsp_ready,
   output logic              rsp_valid,
   output logic [1:0]        rsp_kind,
   output logic [6:0]        rsp_name_char,
   output logic              rsp_is_directory,
   output logic [31:0]       rsp_file_size,
   output logic [31:0]       rsp_start_cluster,
   output logic              rsp_last
);
   logic [4:0]          pos_ff, pos_in;
   logic                ended_ff, ended_in;
   logic                have_long_ff, have_long_in;
   logic [NAME_LEN-1:0] vld_ff, vld_in;
   logic [IDX_W-1:0]    ctr_ff, ctr_in;
   logic [CIDX_W-1:0]   base_ff, base_in;
   logic [7:0]          name_ff [SN_LEN];
   logic [7:0]          name_in [SN_LEN];
   logic [7:0]          attr_ff, attr_in;
   logic [15:0]         lfn_ff [LFN_CHARS];
   logic [15:0]         lfn_in [LFN_CHARS];
   logic [31:0]         size_ff, size_in;
   logic [31:0]         clus_ff, clus_in;

   logic              rv_ff, rv_in;
   logic [1:0]        kind_ff, kind_in;
   logic [6:0]        char_ff, char_in;
   logic              dir_ff, dir_in;
   logic [31:0]       osize_ff, osize_in;
   logic [31:0]       oclus_ff, oclus_in;
   logic              last_ff, last_in;

   logic [4:0]        eff_pos;
   logic              eff_ended;
   logic [4:0]        order;
   logic [CIDX_W-1:0] cidx;
   logic [IDX_W-1:0]  widx;
   logic [15:0]       code;
   logic              pad, over, stop, wr_en;
   logic [6:0]        wr_data;
   logic [6:0]        ram_q;
   logic [7:0]        sn_byte;
   logic              out_free;

   assign eff_pos   = start_directory ? 5'd0 : pos_ff;
   assign eff_ended = start_directory ? 1'b0 : ended_ff;
   assign order     = name_ff[0][4:0] & ORDER_MASK;
   assign cidx      = base_ff + CIDX_W'(ctr_ff);
   assign widx      = cidx[IDX_W-1:0];
   assign code      = lfn_ff[ctr_ff[3:0]];
   assign pad       = (code == 16'h0000) || (code == PAD_CODE);
   assign over      = cidx >= CIDX_W'(NAME_LEN - 1);
   assign stop      = over || (pad && !vld_ff[widx]);
   assign wr_en     = cmd.chunk_step && !stop && !pad;
   assign wr_data   = (code < 16'd128) ? code[6:0] : QMARK_CHAR;
   assign sn_byte   = (ctr_ff < IDX_W'(SN_LEN)) ? name_ff[ctr_ff[3:0]] : SPACE_CHAR;
   assign out_free  = !rv_ff || rsp_ready;

   always_comb begin
      sts            = '0;
      sts.drop       = eff_ended;
      sts.end_byte   = !eff_ended && eff_pos == 5'd0 && data_byte == 8'h00;
      sts.last_byte  = !eff_ended && !sts.end_byte && eff_pos == 5'd31;
      sts.is_lfn     = name_ff[0] != DELETED_MARK && attr_ff[3:0] == LFN_ATTR;
      sts.skip_entry = name_ff[0] == DELETED_MARK || (!sts.is_lfn && attr_ff[ATTR_LABEL]);
      sts.lfn_go     = order != 5'd0;
      sts.have_long  = have_long_ff;
      sts.chunk_done = stop || ctr_ff == IDX_W'(LFN_CHARS - 1);
      sts.ln_more    = ctr_ff < IDX_W'(MAX_CHARS) && vld_ff[ctr_ff];
      sts.name_sp    = sn_byte == SPACE_CHAR;
      sts.ctr_is8    = ctr_ff == IDX_W'(8);
      sts.ctr_is11   = ctr_ff == IDX_W'(SN_LEN);
      sts.ext_blank  = name_ff[8] == SPACE_CHAR;
      sts.out_free   = out_free;
   end

   always_comb begin
      pos_in       = pos_ff;
      ended_in     = ended_ff;
      have_long_in = have_long_ff;
      vld_in       = vld_ff;
      ctr_in       = ctr_ff;
      base_in      = base_ff;
      name_in      = name_ff;
      attr_in      = attr_ff;
      lfn_in       = lfn_ff;
      size_in      = size_ff;
      clus_in      = clus_ff;

      if (cmd.take) begin
         if (start_directory) begin
            pos_in       = 5'd0;
            ended_in     = 1'b0;
            have_long_in = 1'b0;
            vld_in       = '0;
         end
         if (!eff_ended) begin
            if (sts.end_byte) begin
               ended_in = 1'b1;
            end else begin
               pos_in = eff_pos + 5'd1;
               for (int i = 0; i < SN_LEN; i++) begin
                  if (eff_pos == 5'(i)) begin
                     name_in[i] = data_byte;
                  end
               end
               if (eff_pos == 5'd11) begin
                  attr_in = data_byte;
               end
               for (int k = 0; k < LFN_CHARS; k++) begin
                  if (eff_pos == LFN_OFS[k]) begin
                     lfn_in[k][7:0] = data_byte;
                  end
                  if (eff_pos == LFN_OFS[k] + 5'd1) begin
                     lfn_in[k][15:8] = data_byte;
                  end
               end
               case (eff_pos)
                  5'd20:   clus_in[23:16] = data_byte;
                  5'd21:   clus_in[31:24] = data_byte;
                  5'd26:   clus_in[7:0]   = data_byte;
                  5'd27:   clus_in[15:8]  = data_byte;
                  5'd28:   size_in[7:0]   = data_byte;
                  5'd29:   size_in[15:8]  = data_byte;
                  5'd30:   size_in[23:16] = data_byte;
                  5'd31:   size_in[31:24] = data_byte;
                  default: ;
               endcase
            end
         end
      end

      if (cmd.fin) begin
         base_in = CIDX_W'(order - 5'd1) * CIDX_W'(LFN_CHARS);
         if (sts.skip_entry) begin
            have_long_in = 1'b0;
         end else if (sts.is_lfn) begin
            if ((name_ff[0] & LAST_LFN_BIT) != 8'h00) begin
               vld_in = '0;
            end
            if (sts.lfn_go) begin
               have_long_in = 1'b1;
            end
         end
      end

      if (wr_en) begin
         vld_in[widx] = 1'b1;
      end

      if (cmd.emit == EM_INFO) begin
         have_long_in = 1'b0;
      end

      if (cmd.ctr_clr) begin
         ctr_in = '0;
      end else if (cmd.ctr_set8) begin
         ctr_in = IDX_W'(8);
      end else if (cmd.ctr_inc) begin
         ctr_in = ctr_ff + IDX_W'(1);
      end
   end

   // result word register
   always_comb begin
      rv_in    = rv_ff;
      kind_in  = kind_ff;
      char_in  = char_ff;
      dir_in   = dir_ff;
      osize_in = osize_ff;
      oclus_in = oclus_ff;
      last_in  = last_ff;
      if (rsp_ready) begin
         rv_in = 1'b0;
      end
      if (cmd.emit != EM_NONE) begin
         rv_in    = 1'b1;
         kind_in  = KIND_CHAR;
         char_in  = 7'd0;
         dir_in   = 1'b0;
         osize_in = 32'd0;
         oclus_in = 32'd0;
         last_in  = 1'b0;
         case (cmd.emit)
            EM_END: begin
               kind_in = KIND_END;
               last_in = 1'b1;
            end
            EM_INFO: begin
               kind_in  = KIND_INFO;
               dir_in   = attr_ff[ATTR_DIR];
               osize_in = size_ff;
               oclus_in = clus_ff;
               last_in  = 1'b1;
            end
            EM_LONG:  char_in = ram_q;
            EM_SHORT: char_in = lower_char(sn_byte);
            EM_DOT:   char_in = DOT_CHAR;
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 5'd0;
         ended_ff     <= 1'b0;
         have_long_ff <= 1'b0;
         vld_ff       <= '0;
         ctr_ff       <= '0;
         rv_ff        <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         ended_ff     <= ended_in;
         have_long_ff <= have_long_in;
         vld_ff       <= vld_in;
         ctr_ff       <= ctr_in;
         rv_ff        <= rv_in;
      end
      base_ff  <= base_in;
      name_ff  <= name_in;
      attr_ff  <= attr_in;
      lfn_ff   <= lfn_in;
      size_ff  <= size_in;
      clus_ff  <= clus_in;
      kind_ff  <= kind_in;
      char_ff  <= char_in;
      dir_ff   <= dir_in;
      osize_ff <= osize_in;
      oclus_ff <= oclus_in;
      last_ff  <= last_in;
   end

   fdep_ram #(
      .WIDTH (7),
      .DEPTH (NAME_LEN)
   ) u_name_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (widx),
      .wdata (wr_data),
      .re    (cmd.ln_read),
      .raddr (ctr_ff),
      .rdata (ram_q)
   );

   assign rsp_valid         = rv_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_name_char     = char_ff;
   assign rsp_is_directory  = dir_ff;
   assign rsp_file_size     = osize_ff;
   assign rsp_start_cluster = oclus_ff;
   assign rsp_last          = last_ff;
endmodule
`default_nettype wire

// ===== sv/fat_directory_entry_parser.sv =====
// Input word: bytes are taken only in S_IDLE; byte 31 of an entry adds the S_FIN decode.
// Long-name entry: S_LFN stores up to 13 name character slots, one slot per cycle.
// Regular entry: short-name chars, or per long-name char a RAM read (S_LN_RD) then the
// result register (S_LN_EM); then the info word; all wait for a free result register.
// Result register sits after the decode, so rsp_valid rises in the cycle after the emit.
// Synchronous active-high reset clears control state and the name-store valid bits.
`default_nettype none
module fat_directory_entry_parser import fdep_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   fdep_req_if.sink req_chan,
   fdep_rsp_if.source rsp_chan
);
   fdep_cmd_type cmd;
   fdep_sts_type sts;

   fdep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   fdep_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .data_byte         (req_chan.data_byte),
      .start_directory   (req_chan.start_directory),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_kind          (rsp_chan.kind),
      .rsp_name_char     (rsp_chan.name_char),
      .rsp_is_directory  (rsp_chan.is_directory),
      .rsp_file_size     (rsp_chan.file_size),
      .rsp_start_cluster (rsp_chan.start_cluster),
      .rsp_last          (rsp_chan.last)
   );
endmodule
`default_nettype wire

// ===== bench/fdep_channels.sv =====
`timescale 1ns / 100ps

// ===== bench/fat_directory_entry_parser_test.sv =====
`timescale 1ns / 100ps
module fat_directory_entry_parser_test;
   import fdep_pkg::*;

   typedef struct {
      logic [7:0] data_byte;
      logic       start_directory;
   } dir_word_t;

   typedef struct {
      logic [1:0]  kind;
      logic [6:0]  name_char;
      logic        is_directory;
      logic [31:0] file_size;
      logic [31:0] start_cluster;
      logic        last;
   } listing_word_t;

   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fdep_req_if req_chan();
   fdep_rsp_if rsp_chan();

   fat_directory_entry_parser dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   dir_word_t     byte_queue[$];
   listing_word_t listing_queue[$];
   int            errors = 0;
   bit            calm = 1'b0;
   bit            feed_done = 1'b0;
   bit            drain_hold = 1'b0;

   // parser shadow state
   logic [7:0] shadow_entry [32];
   logic [4:0] shadow_pos;
   logic [6:0] shadow_name [NAME_LEN];
   bit         shadow_long;
   bit         shadow_ended;

   function automatic void clear_shadow();
      foreach (shadow_entry[i]) shadow_entry[i] = 8'h00;
      foreach (shadow_name[i]) shadow_name[i] = 7'h00;
      shadow_pos = 5'd0;
      shadow_long = 1'b0;
      shadow_ended = 1'b0;
   endfunction

   function automatic logic [15:0] entry_half(int p);
      return {shadow_entry[(p + 1) % 32], shadow_entry[p % 32]};
   endfunction

   function automatic logic [6:0] fold_case(logic [7:0] c);
      if (c >= 8'h80) return 7'h3F;
      if (c >= 8'h41 && c <= 8'h5A) return c[6:0] + 7'h20;
      return c[6:0];
   endfunction

   function automatic void push_char(logic [6:0] c);
      listing_word_t w;
      w = '{KIND_CHAR, c, 1'b0, 32'd0, 32'd0, 1'b0};
      listing_queue.push_back(w);
   endfunction

   function automatic void close_entry();
      logic [7:0] first;
      logic [7:0] attr;
      int         base;
      int         idx;
      logic [15:0] v;
      int          n;
      listing_word_t w;
      first = shadow_entry[0];
      attr = shadow_entry[11];
      if (first == 8'hE5) begin
         shadow_long = 1'b0;
         return;
      end
      if (attr[3:0] == 4'hF) begin
         if (first[6]) foreach (shadow_name[i]) shadow_name[i] = 7'h00;
         if (first[4:0] >= 1) begin
            base = (int'(first[4:0]) - 1) * 13;
            for (int i = 0; i < 13; i++) begin
               idx = base + i;
               if (idx >= NAME_LEN - 1) break;
               v = entry_half(LFN_OFS[i]);
               if (v == 16'h0000 || v == 16'hFFFF) begin
                  if (shadow_name[idx] == 7'h00) break;
                  continue;
               end
               shadow_name[idx] = (v < 16'd128) ? v[6:0] : 7'h3F;
            end
            shadow_long = 1'b1;
         end
         return;
      end
      if (attr[3]) begin
         shadow_long = 1'b0;
         return;
      end
      if (shadow_long) begin
         n = 0;
         for (int i = 0; i < NAME_LEN - 1 && n < 63; i++) begin
            if (shadow_name[i] == 7'h00) break;
            push_char(shadow_name[i]);
            n++;
         end
      end else begin
         for (int i = 0; i < 8; i++) begin
            if (shadow_entry[i] == 8'h20) break;
            push_char(fold_case(shadow_entry[i]));
         end
         if (shadow_entry[8] != 8'h20) begin
            push_char(7'h2E);
            for (int i = 8; i < 11; i++) begin
               if (shadow_entry[i] == 8'h20) break;
               push_char(fold_case(shadow_entry[i]));
            end
         end
      end
      w = '{KIND_INFO, 7'h00, attr[4], {entry_half(30), entry_half(28)},
            {entry_half(20), entry_half(26)}, 1'b1};
      listing_queue.push_back(w);
      shadow_long = 1'b0;
   endfunction

   function automatic void predict_byte(dir_word_t d);
      listing_word_t w;
      if (d.start_directory) clear_shadow();
      if (shadow_ended) return;
      if (shadow_pos == 5'd0 && d.data_byte == 8'h00) begin
         shadow_ended = 1'b1;
         w = '{KIND_END, 7'h00, 1'b0, 32'd0, 32'd0, 1'b1};
         listing_queue.push_back(w);
         return;
      end
      shadow_entry[shadow_pos] = d.data_byte;
      shadow_pos = shadow_pos + 5'd1;
      if (shadow_pos == 5'd0) close_entry();
   endfunction

   // ---------------- stimulus building
   function automatic void put_byte(logic [7:0] b, bit st = 1'b0);
      dir_word_t d;
      d.data_byte = b;
      d.start_directory = st;
      byte_queue.push_back(d);
   endfunction

   function automatic void put_entry(logic [7:0] e [32], bit st = 1'b0);
      for (int i = 0; i < 32; i++) put_byte(e[i], st && i == 0);
   endfunction

   function automatic void short_entry(output logic [7:0] e [32], input bit wild);
      for (int i = 0; i < 32; i++) e[i] = $urandom_range(0, 255);
      for (int i = 0; i < 11; i++) begin
         if (!wild) e[i] = ($urandom_range(0, 3) == 0) ? 8'h20 : $urandom_range(8'h21, 8'h7E);
      end
      if (e[0] == 8'h00 || e[0] == 8'hE5) e[0] = 8'h41;
      e[11] = $urandom_range(0, 255) & 8'hF7 | ($urandom_range(0, 1) ? 8'h10 : 8'h00);
      if (e[11][3:0] == 4'hF) e[11][0] = 1'b0;
   endfunction

   function automatic void long_entry(output logic [7:0] e [32], input int ord, bit top,
                                      int stop_at);
      logic [15:0] v;
      for (int i = 0; i < 32; i++) e[i] = $urandom_range(0, 255);
      e[0] = ord[4:0] | (top ? 8'h40 : 8'h00) | ($urandom_range(0, 1) ? 8'h80 : 8'h00);
      e[11] = 8'h0F | ($urandom_range(0, 255) & 8'hF0);
      for (int i = 0; i < 13; i++) begin
         case ($urandom_range(0, 9))
            0: v = $urandom_range(128, 65534);
            1: v = 16'hFFFF;
            default: v = $urandom_range(32, 126);
         endcase
         if (i >= stop_at) v = (i == stop_at) ? 16'h0000 : 16'hFFFF;
         e[LFN_OFS[i]] = v[7:0];
         e[LFN_OFS[i] + 1] = v[15:8];
      end
   endfunction

   function automatic void random_file(bit wild);
      logic [7:0] e [32];
      int parts;
      if ($urandom_range(0, 1)) begin
         parts = $urandom_range(1, 5);
         for (int p = parts; p >= 1; p--) begin
            long_entry(e, p, p == parts, $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 13);
            put_entry(e);
         end
      end
      short_entry(e, wild);
      put_entry(e);
   endfunction

   initial begin
      logic [7:0] e [32];
      int count;
      logic [87:0] short_text;
      clear_shadow();
      short_text = "README  TXT";
      // directed: short name with ext, max sizes
      short_entry(e, 1'b0);
      for (int i = 0; i < 11; i++) e[i] = short_text[87 - 8 * i -: 8];
      e[11] = 8'h10;
      for (int i = 20; i < 32; i++) e[i] = 8'hFF;
      put_entry(e, 1'b1);
      // high bytes in short name, blank ext, zero fields
      for (int i = 0; i < 32; i++) e[i] = 8'h00;
      for (int i = 0; i < 11; i++) e[i] = (i < 8) ? 8'h80 + 8'(i * 16) + 8'h0F : 8'h20;
      e[11] = 8'h01;
      put_entry(e);
      e[0] = 8'hE5; put_entry(e);
      short_entry(e, 1'b0); e[11] = 8'h08; put_entry(e);
      long_entry(e, 0, 1'b1, 13); put_entry(e);
      short_entry(e, 1'b0); put_entry(e);
      long_entry(e, 31, 1'b1, 13); put_entry(e);
      long_entry(e, 5, 1'b0, 13); put_entry(e);
      long_entry(e, 1, 1'b0, 4); put_entry(e);
      short_entry(e, 1'b1); put_entry(e);
      put_byte(8'h00);
      put_byte(8'h55); put_byte(8'h00);
      count = byte_queue.size();
      while (count < 320) begin
         case ($urandom_range(0, 9))
            0: begin
               short_entry(e, 1'b1);
               e[0] = 8'hE5; put_entry(e, $urandom_range(0, 1));
            end
            1: begin
               put_byte(8'h00, $urandom_range(0, 1));
               repeat ($urandom_range(0, 5)) put_byte($urandom_range(0, 255));
               put_byte($urandom_range(1, 255), 1'b1);
               repeat (31) put_byte($urandom_range(0, 255));
            end
            2: put_byte($urandom_range(1, 255), 1'b1);
            default: random_file($urandom_range(0, 3) == 0);
         endcase
         count = byte_queue.size();
         if (count > 130 && count < 180 && !drain_hold) drain_hold = 1'b1;
      end
      put_byte(8'h00);
      feed_done = 1'b1;
   end

   // ---------------- driver
   int  send_gap = 0;
   int  sent = 0;
   int  issued = 0;
   bit  paused_once = 1'b0;
   int  drain_mark = 0;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data_byte = 8'h00;
      req_chan.start_directory = 1'b0;
      rsp_chan.ready = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
         end
         calm <= (byte_queue.size() < 60 && feed_done);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         predict_byte('{req_chan.data_byte, req_chan.start_directory});
         sent <= sent + 1;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_chan.valid && issued != sent) begin
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (!paused_once && sent == 150 && listing_queue.size() != 0) begin
            req_chan.valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 19) == 0) begin
            send_gap <= $urandom_range(0, 12);
            req_chan.valid <= 1'b0;
         end else if (byte_queue.size() != 0 && feed_done) begin
            if (sent == 150) paused_once <= 1'b1;
            req_chan.valid <= 1'b1;
            {req_chan.data_byte, req_chan.start_directory} <=
               {byte_queue[0].data_byte, byte_queue[0].start_directory};
            void'(byte_queue.pop_front());
            issued <= issued + 1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // ---------------- monitor
   int stall = 0;

   always @(negedge clock) begin
      if (!reset) begin
         if (stall > 0) begin
            stall <= stall - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 15) == 0) begin
            stall <= $urandom_range(0, 12);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      listing_word_t x;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (listing_queue.size() == 0) begin
            $error("unexpected result kind=%0d", rsp_chan.kind);
            errors++;
         end else begin
            x = listing_queue.pop_front();
            if (rsp_chan.kind !== x.kind) begin
               $error("kind exp %0d got %0d", x.kind, rsp_chan.kind); errors++;
            end
            if (rsp_chan.name_char !== x.name_char) begin
               $error("name_char exp %h got %h", x.name_char, rsp_chan.name_char); errors++;
            end
            if (rsp_chan.is_directory !== x.is_directory) begin
               $error("is_directory exp %0d got %0d", x.is_directory, rsp_chan.is_directory);
               errors++;
            end
            if (rsp_chan.file_size !== x.file_size) begin
               $error("file_size exp %h got %h", x.file_size, rsp_chan.file_size); errors++;
            end
            if (rsp_chan.start_cluster !== x.start_cluster) begin
               $error("start_cluster exp %h got %h", x.start_cluster, rsp_chan.start_cluster);
               errors++;
            end
            if (rsp_chan.last !== x.last) begin
               $error("last exp %0d got %0d", x.last, rsp_chan.last); errors++;
            end
         end
      end
   end

   // ---------------- watchdog and end
   int quiet = 0;

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      wait (feed_done);
      wait (byte_queue.size() == 0 && !req_chan.valid);
      wait (listing_queue.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && listing_queue.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
